@@ rtl/ihs_pkg.sv @@
// Shared constants, types and codes for the inode dedup hash set.
package ihs_pkg;

  // Table geometry; SLOTS must be a power of two.
  localparam int SLOTS      = 1024;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int COUNT_W    = IDX_W + 1;
  localparam int LOAD_LIMIT = SLOTS - SLOTS / 4;

  // Key field widths.
  localparam int DEV_W = 32;
  localparam int INO_W = 64;

  // Mixer multipliers.
  localparam logic [63:0] MIX_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;

  // Result codes.
  typedef enum logic [1:0] {
    VERDICT_NEW  = 2'd0,
    VERDICT_SEEN = 2'd1,
    VERDICT_FULL = 2'd2
  } verdict_t;

  // Mixer phases, one per 64-bit multiply.
  typedef enum logic [1:0] {
    MIX_PH_GOLDEN,
    MIX_PH_A,
    MIX_PH_B
  } mix_phase_t;

  // Top-level control states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CHECK
  } ihs_state_t;

  // One table slot as stored in memory.
  typedef struct packed {
    logic             used;
    logic [DEV_W-1:0] dev;
    logic [INO_W-1:0] ino;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Handshake between the controller and the mixer.
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] slot;
  } hash_rsp_t;

endpackage

@@ rtl/inode_dedup_hash_set.sv @@
// Top level: (device, inode) dedup set with linear probing over one slot RAM.
//
// Usage: drive in_device_id and in_inode_number with start high; the item is
// taken at a rising edge where start is high and busy is low. busy stays high
// until the verdict is out. One result per item appears on out_verdict for a
// single cycle with out_valid high; the receiver cannot stall it, and a new
// start is taken in that same cycle.
// Verdicts: 0 new key stored, 1 key already present, 2 table full and refused.
// Each item passes through key mixing on a single 32x32 multiplier (three
// 64-bit multiplies, four steps each), loading of the start slot, a slot
// RAM read and compare for each probe, then the output register. No new
// item is taken until the verdict of the last one is out; probing runs
// longest for absent keys near the load limit.
// Capacity is fixed: once three quarters of the slots are used, absent keys
// get verdict 2 while stored keys still answer 1.
// Reset (rst_n low, synchronous) starts a clearing pass that zeroes every
// slot; busy is high throughout and no item is accepted until it ends.
module inode_dedup_hash_set (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [ihs_pkg::DEV_W-1:0] in_device_id,
  input  logic [ihs_pkg::INO_W-1:0] in_inode_number,
  output logic                      out_valid,
  output logic [1:0]                out_verdict
);
  import ihs_pkg::*;

  ihs_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [COUNT_W-1:0] probes_r, probes_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [DEV_W-1:0]   key_dev_r, key_dev_nxt;
  logic [INO_W-1:0]   key_ino_r, key_ino_nxt;
  logic               out_valid_r, out_valid_nxt;
  verdict_t           verdict_r, verdict_nxt;

  logic               accept;
  hash_rsp_t          hash_rsp;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;
  logic               key_match;
  logic               table_full;
  logic               probe_bound;
  logic               clr_last;

  assign accept = start && (state_r == ST_IDLE);

  // Key mixer.
  ihs_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .dev   (in_device_id),
    .ino   (in_inode_number),
    .rsp   (hash_rsp)
  );

  // Slot store: used mark plus key, read at the current probe position.
  ihs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  assign rd_entry    = entry_t'(ram_rdata);
  assign key_match   = (rd_entry.dev == key_dev_r) && (rd_entry.ino == key_ino_r);
  assign table_full  = count_r >= COUNT_W'(LOAD_LIMIT);
  assign probe_bound = probes_r == COUNT_W'(SLOTS - 1);
  assign clr_last    = clr_idx_r == IDX_W'(SLOTS - 1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_HASH;
      ST_HASH:  if (hash_rsp.done) state_nxt = ST_PROBE;
      ST_PROBE: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!rd_entry.used || key_match || probe_bound) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs, memory writes and datapath updates.
  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    pos_nxt       = pos_r;
    probes_nxt    = probes_r;
    count_nxt     = count_r;
    key_dev_nxt   = key_dev_r;
    key_ino_nxt   = key_ino_r;
    out_valid_nxt = 1'b0;
    verdict_nxt   = verdict_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = '{used: 1'b1, dev: key_dev_r, ino: key_ino_r};
    unique case (state_r)
      ST_CLEAR: begin
        // Zero one slot per cycle.
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          key_dev_nxt = in_device_id;
          key_ino_nxt = in_inode_number;
        end
      end
      ST_HASH: begin
        if (hash_rsp.done) begin
          pos_nxt    = hash_rsp.slot;
          probes_nxt = '0;
        end
      end
      ST_PROBE: begin
      end
      ST_CHECK: begin
        if (!rd_entry.used) begin
          // Empty slot: store the key unless the load limit is reached.
          out_valid_nxt = 1'b1;
          if (table_full) begin
            verdict_nxt = VERDICT_FULL;
          end else begin
            ram_we      = 1'b1;
            count_nxt   = count_r + 1'b1;
            verdict_nxt = VERDICT_NEW;
          end
        end else if (key_match) begin
          out_valid_nxt = 1'b1;
          verdict_nxt   = VERDICT_SEEN;
        end else if (probe_bound) begin
          out_valid_nxt = 1'b1;
          verdict_nxt   = VERDICT_FULL;
        end else begin
          // Advance to the next slot, wrapping at the table end.
          pos_nxt    = pos_r + 1'b1;
          probes_nxt = probes_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    probes_r  <= probes_nxt;
    key_dev_r <= key_dev_nxt;
    key_ino_r <= key_ino_nxt;
    verdict_r <= verdict_nxt;
  end

  assign busy        = state_r != ST_IDLE;
  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

endmodule

@@ rtl/ihs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
module ihs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ihs_hash.sv @@
// Sequential splitmix64-style key mixer built around one 32x32 multiplier.
module ihs_hash (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [ihs_pkg::DEV_W-1:0] dev,
  input  logic [ihs_pkg::INO_W-1:0] ino,
  output ihs_pkg::hash_rsp_t      rsp
);
  import ihs_pkg::*;

  localparam logic [1:0] LAST_STEP = 2'd3;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  mix_phase_t       phase_r, phase_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [63:0]      x_r, x_nxt;
  logic [DEV_W-1:0] dev_r, dev_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [63:0]      acc_r, acc_nxt;

  logic [63:0] mul_k;
  logic [31:0] op_a, op_b;
  logic [63:0] sum;
  logic [63:0] pre;

  // Pick the multiplier constant for this phase.
  always_comb begin
    unique case (phase_r)
      MIX_PH_GOLDEN: mul_k = MIX_GOLDEN;
      MIX_PH_A:      mul_k = MIX_MUL_A;
      MIX_PH_B:      mul_k = MIX_MUL_B;
      default:       mul_k = MIX_GOLDEN;
    endcase
  end

  // Low 64 bits of x * k: lo*lo, then the two cross terms shifted up.
  assign op_a     = (step_r == 2'd1) ? x_r[63:32] : x_r[31:0];
  assign op_b     = (step_r == 2'd2) ? mul_k[63:32] : mul_k[31:0];
  assign prod_nxt = {32'd0, op_a} * {32'd0, op_b};
  assign sum      = acc_r + {prod_r[31:0], 32'd0};
  assign pre      = {{(64 - DEV_W){1'b0}}, dev_r} ^ sum;

  // Advance the step sequence and fold each product into the mix.
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    x_nxt     = x_r;
    dev_nxt   = dev_r;
    acc_nxt   = acc_r;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = MIX_PH_GOLDEN;
      step_nxt  = '0;
      x_nxt     = ino;
      dev_nxt   = dev;
    end else if (busy_r) begin
      step_nxt = step_r + 2'd1;
      case (step_r)
        2'd1:    acc_nxt = prod_r;
        2'd2:    acc_nxt = sum;
        default: acc_nxt = acc_r;
      endcase
      if (step_r == LAST_STEP) begin
        unique case (phase_r)
          MIX_PH_GOLDEN: begin
            x_nxt     = pre ^ (pre >> 30);
            phase_nxt = MIX_PH_A;
          end
          MIX_PH_A: begin
            x_nxt     = sum ^ (sum >> 27);
            phase_nxt = MIX_PH_B;
          end
          MIX_PH_B: begin
            x_nxt    = sum ^ (sum >> 31);
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
          default: begin
            busy_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  // Hold control state under reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= MIX_PH_GOLDEN;
      step_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    dev_r  <= dev_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.slot = x_r[IDX_W-1:0];

endmodule
